// ===== rtl/pfe_pkg.sv =====
`default_nettype none

package pfe_pkg;

    // Field and store widths
    localparam int BYTE_W     = 8;
    localparam int ARG_W      = 64;
    localparam int BIN_W      = 32;
    localparam int COUNT_W    = 31;
    localparam int DEC_DIGITS = 10;
    localparam int BCD_W      = 4 * DEC_DIGITS;
    localparam int HEX_DIGITS = ARG_W / 4;
    localparam int DCNT_W     = $clog2(HEX_DIGITS + 1);
    localparam int PRE_BYTES  = 5;
    localparam int PRE_W      = BYTE_W * PRE_BYTES;
    localparam int PCNT_W     = $clog2(PRE_BYTES + 1);
    localparam int BITCNT_W   = $clog2(BIN_W);

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // ASCII codes
    localparam logic [BYTE_W-1:0] CH_NUL     = 8'h00;
    localparam logic [BYTE_W-1:0] CH_PERCENT = 8'h25;
    localparam logic [BYTE_W-1:0] CH_MINUS   = 8'h2D;
    localparam logic [BYTE_W-1:0] CH_ZERO    = 8'h30;
    localparam logic [BYTE_W-1:0] CH_LOW_X   = 8'h78;
    localparam logic [BYTE_W-1:0] CH_LOW_A   = 8'h61;
    localparam logic [BYTE_W-1:0] CH_UP_A    = 8'h41;
    localparam logic [BYTE_W-1:0] CH_LOW_C   = 8'h63;
    localparam logic [BYTE_W-1:0] CH_LOW_D   = 8'h64;
    localparam logic [BYTE_W-1:0] CH_LOW_I   = 8'h69;
    localparam logic [BYTE_W-1:0] CH_LOW_U   = 8'h75;
    localparam logic [BYTE_W-1:0] CH_UP_X    = 8'h58;
    localparam logic [BYTE_W-1:0] CH_LOW_P   = 8'h70;

    // Prefix strings, first byte in the top position
    localparam logic [PRE_W-1:0] NIL_TEXT   = 40'h28_6E_69_6C_29;
    localparam logic [PRE_W-1:0] HEX_PREFIX = {CH_ZERO, CH_LOW_X, 24'h0};

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_CONV = 4'b0010,
        ST_NORM = 4'b0100,
        ST_EMIT = 4'b1000
    } state_t;

    // Digit value to ASCII, decimal or hex
    function automatic logic [BYTE_W-1:0] digit_char(input logic [3:0] nib,
                                                     input logic upper);
        logic [BYTE_W-1:0] wide;
        wide = {4'h0, nib};
        if (nib < 4'd10) begin
            digit_char = CH_ZERO + wide;
        end else begin
            digit_char = (upper ? CH_UP_A : CH_LOW_A) + wide - 8'd10;
        end
    endfunction

endpackage

`default_nettype wire

// ===== rtl/pfe_bin2bcd.sv =====
`default_nettype none

module pfe_bin2bcd (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [pfe_pkg::BIN_W-1:0]     bin,
    output logic                          done,
    output logic [pfe_pkg::BCD_W-1:0]     bcd
);
    import pfe_pkg::*;

    logic                busy_reg,  busy_next;
    logic                done_reg,  done_next;
    logic [BITCNT_W-1:0] cnt_reg,   cnt_next;
    logic [BIN_W-1:0]    bin_reg,   bin_next;
    logic [BCD_W-1:0]    bcd_reg,   bcd_next;
    logic [BCD_W-1:0]    adj;

    // Add three to every digit of five or more before the shift
    always_comb
    begin
        for (int i = 0; i < DEC_DIGITS; i++)
        begin
            if (bcd_reg[4*i +: 4] >= 4'd5) begin
                adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            end else begin
                adj[4*i +: 4] = bcd_reg[4*i +: 4];
            end
        end
    end

    // Shift one binary bit into the digit word each cycle
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        bin_next  = bin_reg;
        bcd_next  = bcd_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            bin_next  = bin;
            bcd_next  = '0;
        end else if (busy_reg) begin
            bcd_next = {adj[BCD_W-2:0], bin_reg[BIN_W-1]};
            bin_next = {bin_reg[BIN_W-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == BITCNT_W'(BIN_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    assign done = done_reg;
    assign bcd  = bcd_reg;

endmodule

`default_nettype wire

// ===== rtl/printf_format_engine_unit.sv =====
// Streaming printf-style formatter.
// Input channel: in_valid/in_stall carry one format byte (fmt_byte) with its
// argument (arg_value). Output channel: out_valid/out_stall carry one ASCII
// byte (out_byte), a flag on the final byte of an item (last), and the
// saturating count of bytes emitted so far including this one (total_count).
// A literal byte or single-character conversion is placed in the prefix
// register on acceptance and sent from the emit state. Hex conversions
// strip leading zeros, one nibble a cycle, keeping at least one of the 8
// digits of %x and %X or the 16 of %p, then send one byte a cycle. Decimal
// conversions first wait on the shift-and-add-three BCD converter, then
// strip or send each of the 10 digits, one a cycle, after the sign. Bytes
// go out at that rate only while the receiver keeps up.
// The input is stalled from acceptance until the last byte of the item
// has been loaded into the output register, so items are handled one at a
// time; the next item may be taken while that last byte still waits.
// A '%', a NUL, or an unknown selector produces nothing and the input is
// ready again in the next cycle.
// Reset clears the pending '%', the byte count and the output valid flag.
// While out_stall is high and a byte is valid, that byte holds and the emit state waits.
`default_nettype none

module printf_format_engine_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [pfe_pkg::BYTE_W-1:0]    fmt_byte,
    input  logic [pfe_pkg::ARG_W-1:0]     arg_value,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [pfe_pkg::BYTE_W-1:0]    out_byte,
    output logic                          last,
    output logic [pfe_pkg::COUNT_W-1:0]   total_count
);
    import pfe_pkg::*;

    state_t              state_reg,     state_next;
    logic                pending_reg,   pending_next;
    logic [PRE_W-1:0]    pre_reg,       pre_next;
    logic [PCNT_W-1:0]   pre_cnt_reg,   pre_cnt_next;
    logic [ARG_W-1:0]    dig_reg,       dig_next;
    logic [DCNT_W-1:0]   dig_cnt_reg,   dig_cnt_next;
    logic                upper_reg,     upper_next;
    logic [COUNT_W-1:0]  count_reg,     count_next;
    logic                out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0]   out_byte_reg,  out_byte_next;
    logic                out_last_reg,  out_last_next;

    logic                in_accept;
    logic                out_free;
    logic                emit_go;
    logic [BYTE_W-1:0]   emit_byte;
    logic                emit_last;
    logic                is_dec;
    logic                neg;
    logic [BIN_W-1:0]    low;
    logic                bcd_start;
    logic [BIN_W-1:0]    bcd_bin;
    logic                bcd_done;
    logic [BCD_W-1:0]    bcd;

    assign in_accept = in_valid && (state_reg == ST_IDLE);
    assign in_stall  = (state_reg != ST_IDLE);
    assign out_free  = !out_valid_reg || !out_stall;
    assign emit_go   = (state_reg == ST_EMIT) && out_free;

    // Pick the next byte: prefix bytes first, then digits from the top
    assign emit_byte = (pre_cnt_reg != '0) ? pre_reg[PRE_W-1 -: BYTE_W]
                                           : digit_char(dig_reg[ARG_W-1 -: 4], upper_reg);
    assign emit_last = (pre_cnt_reg != '0) ? ((pre_cnt_reg == PCNT_W'(1)) && (dig_cnt_reg == '0))
                                           : (dig_cnt_reg == DCNT_W'(1));

    // Operand for the decimal converter
    assign low       = arg_value[BIN_W-1:0];
    assign is_dec    = (fmt_byte == CH_LOW_D) || (fmt_byte == CH_LOW_I)
                    || (fmt_byte == CH_LOW_U);
    assign neg       = ((fmt_byte == CH_LOW_D) || (fmt_byte == CH_LOW_I)) && low[BIN_W-1];
    assign bcd_bin   = neg ? (BIN_W'(0) - low) : low;
    assign bcd_start = in_accept && pending_reg && is_dec;

    pfe_bin2bcd u_bin2bcd (
        .clk   (clk),
        .rst_n (rst_n),
        .start (bcd_start),
        .bin   (bcd_bin),
        .done  (bcd_done),
        .bcd   (bcd)
    );

    // Sequencer: decode, convert, strip zeros, emit
    always_comb
    begin
        state_next   = state_reg;
        pending_next = pending_reg;
        pre_next     = pre_reg;
        pre_cnt_next = pre_cnt_reg;
        dig_next     = dig_reg;
        dig_cnt_next = dig_cnt_reg;
        upper_next   = upper_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept) begin
                    pre_cnt_next = '0;
                    dig_cnt_next = '0;
                    upper_next   = 1'b0;
                    if (pending_reg) begin
                        pending_next = 1'b0;
                        unique case (fmt_byte) inside
                            CH_PERCENT:
                            begin
                                pre_next     = {CH_PERCENT, 32'h0};
                                pre_cnt_next = PCNT_W'(1);
                                state_next   = ST_EMIT;
                            end
                            CH_LOW_C:
                            begin
                                pre_next     = {arg_value[BYTE_W-1:0], 32'h0};
                                pre_cnt_next = PCNT_W'(1);
                                state_next   = ST_EMIT;
                            end
                            CH_LOW_D, CH_LOW_I, CH_LOW_U:
                            begin
                                pre_next     = {CH_MINUS, 32'h0};
                                pre_cnt_next = neg ? PCNT_W'(1) : PCNT_W'(0);
                                state_next   = ST_CONV;
                            end
                            CH_LOW_X, CH_UP_X:
                            begin
                                dig_next     = {low, 32'h0};
                                dig_cnt_next = DCNT_W'(HEX_DIGITS / 2);
                                upper_next   = (fmt_byte == CH_UP_X);
                                state_next   = ST_NORM;
                            end
                            CH_LOW_P:
                            begin
                                if (arg_value == '0) begin
                                    pre_next     = NIL_TEXT;
                                    pre_cnt_next = PCNT_W'(PRE_BYTES);
                                    state_next   = ST_EMIT;
                                end else begin
                                    pre_next     = HEX_PREFIX;
                                    pre_cnt_next = PCNT_W'(2);
                                    dig_next     = arg_value;
                                    dig_cnt_next = DCNT_W'(HEX_DIGITS);
                                    state_next   = ST_NORM;
                                end
                            end
                            default:
                            begin
                                state_next = ST_IDLE;
                            end
                        endcase
                    end else if (fmt_byte == CH_PERCENT) begin
                        pending_next = 1'b1;
                    end else if (fmt_byte != CH_NUL) begin
                        pre_next     = {fmt_byte, 32'h0};
                        pre_cnt_next = PCNT_W'(1);
                        state_next   = ST_EMIT;
                    end
                end
            end
            ST_CONV:
            begin
                if (bcd_done) begin
                    dig_next     = {bcd, {(ARG_W - BCD_W){1'b0}}};
                    dig_cnt_next = DCNT_W'(DEC_DIGITS);
                    state_next   = ST_NORM;
                end
            end
            ST_NORM:
            begin
                if ((dig_cnt_reg > DCNT_W'(1)) && (dig_reg[ARG_W-1 -: 4] == 4'h0)) begin
                    dig_next     = {dig_reg[ARG_W-5:0], 4'h0};
                    dig_cnt_next = dig_cnt_reg - 1'b1;
                end else begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (emit_go) begin
                    if (pre_cnt_reg != '0) begin
                        pre_next     = {pre_reg[PRE_W-BYTE_W-1:0], 8'h0};
                        pre_cnt_next = pre_cnt_reg - 1'b1;
                    end else begin
                        dig_next     = {dig_reg[ARG_W-5:0], 4'h0};
                        dig_cnt_next = dig_cnt_reg - 1'b1;
                    end
                    if (emit_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output register and saturating byte count
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        count_next     = count_reg;
        if (out_free) begin
            out_valid_next = emit_go;
        end
        if (emit_go) begin
            out_byte_next = emit_byte;
            out_last_next = emit_last;
            if (count_reg != COUNT_MAX) begin
                count_next = count_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= ST_IDLE;
            pending_reg   <= 1'b0;
            pre_cnt_reg   <= '0;
            dig_cnt_reg   <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            pending_reg   <= pending_next;
            pre_cnt_reg   <= pre_cnt_next;
            dig_cnt_reg   <= dig_cnt_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pre_reg      <= pre_next;
        dig_reg      <= dig_next;
        upper_reg    <= upper_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
    end

    assign out_valid   = out_valid_reg;
    assign out_byte    = out_byte_reg;
    assign last        = out_last_reg;
    assign total_count = count_reg;

`ifndef NO_ASSERTIONS
    // The count moves only when a byte is loaded for output
    a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !emit_go |=> $stable(count_reg))
        else $error("byte count changed with no byte emitted");

    // Zero stripping always leaves at least one digit
    a_norm_digits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_NORM) |-> (dig_cnt_reg != '0))
        else $error("digit stripping with no digits left");

    // Emitting always has something left to send
    a_emit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> ((pre_cnt_reg != '0) || (dig_cnt_reg != '0)))
        else $error("emit state with nothing to send");

    // The converter only finishes while the sequencer waits for it
    a_conv_done: assert property (@(posedge clk) disable iff (!rst_n)
        bcd_done |-> (state_reg == ST_CONV))
        else $error("BCD result arrived outside conversion");
`endif

endmodule

`default_nettype wire

// ===== tb/pfe_stream_check.sv =====
`timescale 1ns / 100ps

// Watches both channels of the formatter, works out the bytes each accepted
// format item must produce and compares them with what leaves the block.
module pfe_stream_check (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic                        in_stall,
    input  logic [pfe_pkg::BYTE_W-1:0]  fmt_byte,
    input  logic [pfe_pkg::ARG_W-1:0]   arg_value,
    input  logic                        out_valid,
    input  logic                        out_stall,
    input  logic [pfe_pkg::BYTE_W-1:0]  out_byte,
    input  logic                        last,
    input  logic [pfe_pkg::COUNT_W-1:0] total_count,
    output int                          fail_count,
    output int                          pending_count,
    output int                          bytes_checked
);
    import pfe_pkg::*;

    localparam logic [127:0] HEX_LOWER = "0123456789abcdef";
    localparam logic [127:0] HEX_UPPER = "0123456789ABCDEF";

    typedef struct packed {
        logic [BYTE_W-1:0]  ch;
        logic               fin;
        logic [COUNT_W-1:0] count;
    } out_byte_t;

    // Formatter state as the block should hold it
    logic               pct_waiting;
    logic [COUNT_W-1:0] byte_tally;

    logic [BYTE_W-1:0] text_buf[$];
    out_byte_t         expected_bytes[$];

    int errs;
    int nchk;

    // Append an unsigned value in decimal, no leading zeros
    function automatic void append_decimal(input logic [31:0] v);
        logic [BYTE_W-1:0] tmp[10];
        int k;
        k = 0;
        do
        begin
            tmp[k] = CH_ZERO + BYTE_W'(v % 32'd10);
            k++;
            v = v / 32'd10;
        end
        while (v != 0 && k < 10);
        while (k > 0)
        begin
            k--;
            text_buf.push_back(tmp[k]);
        end
    endfunction

    // Append a value in hex, no leading zeros
    function automatic void append_hex(input logic [63:0] v, input logic upper);
        logic [BYTE_W-1:0] tmp[16];
        int k;
        int nib;
        k = 0;
        do
        begin
            nib = int'(v[3:0]);
            tmp[k] = upper ? HEX_UPPER[127 - 8 * nib -: 8] : HEX_LOWER[127 - 8 * nib -: 8];
            k++;
            v = v >> 4;
        end
        while (v != 0 && k < 16);
        while (k > 0)
        begin
            k--;
            text_buf.push_back(tmp[k]);
        end
    endfunction

    // Work out the bytes caused by one format item and queue them
    function automatic void format_item(input logic [BYTE_W-1:0] c,
                                        input logic [ARG_W-1:0] arg);
        logic [31:0] low;
        out_byte_t   rec;
        int          i;
        low = arg[31:0];
        text_buf.delete();
        if (pct_waiting)
        begin
            pct_waiting = 1'b0;
            case (c) inside
                CH_PERCENT: text_buf.push_back(CH_PERCENT);
                CH_LOW_C:   text_buf.push_back(arg[7:0]);
                CH_LOW_D, CH_LOW_I:
                begin
                    if (low[31])
                    begin
                        text_buf.push_back(CH_MINUS);
                        append_decimal(32'd0 - low);
                    end
                    else
                    begin
                        append_decimal(low);
                    end
                end
                CH_LOW_U:   append_decimal(low);
                CH_LOW_X:   append_hex({32'd0, low}, 1'b0);
                CH_UP_X:    append_hex({32'd0, low}, 1'b1);
                CH_LOW_P:
                begin
                    if (arg == '0)
                    begin
                        for (i = 0; i < PRE_BYTES; i++)
                            text_buf.push_back(NIL_TEXT[PRE_W - 1 - 8 * i -: 8]);
                    end
                    else
                    begin
                        text_buf.push_back(CH_ZERO);
                        text_buf.push_back(CH_LOW_X);
                        append_hex(arg, 1'b0);
                    end
                end
                default: ;
            endcase
        end
        else if (c == CH_PERCENT)
        begin
            pct_waiting = 1'b1;
        end
        else if (c != CH_NUL)
        begin
            text_buf.push_back(c);
        end

        for (i = 0; i < text_buf.size(); i++)
        begin
            if (byte_tally != COUNT_MAX)
                byte_tally++;
            rec.ch    = text_buf[i];
            rec.fin   = (i == text_buf.size() - 1);
            rec.count = byte_tally;
            expected_bytes.push_back(rec);
        end
    endfunction

    // Predict on each accepted item, compare on each accepted byte
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pct_waiting = 1'b0;
            byte_tally  = '0;
            expected_bytes.delete();
            errs = 0;
            nchk = 0;
            fail_count    <= 0;
            pending_count <= 0;
            bytes_checked <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                format_item(fmt_byte, arg_value);

            if (out_valid && !out_stall)
            begin
                if (expected_bytes.size() == 0)
                begin
                    errs++;
                    if (errs <= 10)
                        $display("%t: unexpected byte %02h last %0b count %0d", $realtime,
                                 out_byte, last, total_count);
                end
                else
                begin
                    out_byte_t want;
                    want = expected_bytes.pop_front();
                    nchk++;
                    if (want.ch !== out_byte || want.fin !== last ||
                        want.count !== total_count)
                    begin
                        errs++;
                        if (errs <= 10)
                            $display({"%t: byte %0d expected %02h last %0b count %0d,",
                                      " got %02h last %0b count %0d"},
                                     $realtime, nchk, want.ch, want.fin, want.count,
                                     out_byte, last, total_count);
                    end
                end
            end

            fail_count    <= errs;
            pending_count <= expected_bytes.size();
            bytes_checked <= nchk;
        end
    end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
    import pfe_pkg::*;

    localparam int ITEM_TARGET = 460;
    localparam int HOLD_CYCLES = 300;
    localparam logic [BYTE_W-1:0] CH_LOW_S = 8'h73;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [BYTE_W-1:0]  fmt_byte;
    logic [ARG_W-1:0]   arg_value;
    logic               out_valid;
    logic               out_stall;
    logic [BYTE_W-1:0]  out_byte;
    logic               last;
    logic [COUNT_W-1:0] total_count;

    int fail_count;
    int pending_count;
    int bytes_checked;

    int items_sent;
    int pct_pairs;
    bit steady_in;
    bit hold_off_req;

    printf_format_engine_unit DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .fmt_byte    (fmt_byte),
        .arg_value   (arg_value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_byte    (out_byte),
        .last        (last),
        .total_count (total_count)
    );

    pfe_stream_check stream_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .fmt_byte      (fmt_byte),
        .arg_value     (arg_value),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_byte      (out_byte),
        .last          (last),
        .total_count   (total_count),
        .fail_count    (fail_count),
        .pending_count (pending_count),
        .bytes_checked (bytes_checked)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Argument values weighted towards the awkward corners
    function automatic logic [ARG_W-1:0] rand_arg();
        logic [ARG_W-1:0] v;
        case ($urandom_range(0, 9))
            0: v = '0;
            1: v = '1;
            2: v = {$urandom, 32'h8000_0000};
            3: v = ARG_W'($urandom_range(0, 20));
            4: v = ARG_W'(1) << $urandom_range(0, ARG_W - 1);
            5: v = {32'd0, $urandom} >> $urandom_range(0, 31);
            default: v = {$urandom, $urandom};
        endcase
        return v;
    endfunction

    // One of the known conversion letters
    function automatic logic [BYTE_W-1:0] pick_selector();
        logic [BYTE_W-1:0] s;
        case ($urandom_range(0, 7))
            0: s = CH_PERCENT;
            1: s = CH_LOW_C;
            2: s = CH_LOW_D;
            3: s = CH_LOW_I;
            4: s = CH_LOW_U;
            5: s = CH_LOW_X;
            6: s = CH_UP_X;
            default: s = CH_LOW_P;
        endcase
        return s;
    endfunction

    // Offer one item and hold it until taken
    task automatic send(input logic [BYTE_W-1:0] b, input logic [ARG_W-1:0] a);
        fmt_byte  <= b;
        arg_value <= a;
        in_valid  <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
    endtask

    // Idle for a random gap unless in a steady stretch, then send
    task automatic put_item(input logic [BYTE_W-1:0] b, input logic [ARG_W-1:0] a);
        int r;
        int n;
        n = 0;
        if (!steady_in)
        begin
            r = $urandom_range(0, 99);
            if (r < 45)
                n = 0;
            else if (r < 90)
                n = $urandom_range(1, 3);
            else
                n = $urandom_range(8, 40);
        end
        if (n > 0)
        begin
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
        send(b, a);
    endtask

    // A '%' followed by the selector byte
    task automatic put_conv(input logic [BYTE_W-1:0] sel, input logic [ARG_W-1:0] a);
        put_item(CH_PERCENT, rand_arg());
        put_item(sel, a);
        pct_pairs++;
    endtask

    // Stop offering until every predicted byte has come out
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
    endtask

    // Receiver: random stalls, with one long hold-off on request
    initial
    begin
        int lvl;
        int len;
        out_stall = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                out_stall <= 1'b0;
                @(posedge clk);
            end
            else
            begin
                lvl = int'($urandom_range(0, 99) < 30);
                if (lvl != 0)
                    len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                      : $urandom_range(1, 3);
                else
                    len = $urandom_range(1, 30);
                out_stall <= lvl[0];
                repeat (len) @(posedge clk);
            end
        end
    end

    // Stimulus and verdict
    initial
    begin
        int round;
        int r;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        fmt_byte     = '0;
        arg_value    = '0;
        items_sent   = 0;
        pct_pairs    = 0;
        steady_in    = 1'b0;
        hold_off_req = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: literals, every conversion at its extremes, odd selectors
        put_item(CH_UP_A, '0);
        put_item(8'hFF, '1);
        put_item(8'h01, '0);
        put_item(CH_NUL, '1);
        put_conv(CH_PERCENT, '0);
        put_conv(CH_LOW_C, '1);
        put_conv(CH_LOW_C, '0);
        put_conv(CH_LOW_D, 64'h0000_0000_8000_0000);
        put_conv(CH_LOW_I, '1);
        put_conv(CH_LOW_D, 64'hFFFF_FFFF_7FFF_FFFF);
        put_conv(CH_LOW_U, 64'h0000_0000_FFFF_FFFF);
        put_conv(CH_LOW_X, 64'hFFFF_FFFF_0000_0000);
        put_conv(CH_UP_X, 64'hDEAD_BEEF_CAFE_F00D);
        put_conv(CH_LOW_P, '0);
        put_conv(CH_LOW_P, '1);
        put_conv(CH_LOW_S, '1);
        put_conv(CH_NUL, '0);

        // Random: mostly well-formed conversions, the rest noise
        round = 0;
        while (items_sent < ITEM_TARGET)
        begin
            if (round % 32 == 0)
                steady_in = ($urandom_range(0, 3) == 0);
            if (round == 60)
                hold_off_req = 1'b1;
            if (round == 200)
                drain();
            r = $urandom_range(0, 99);
            if (r < 72)
                put_conv(pick_selector(), rand_arg());
            else if (r < 84)
                put_item(BYTE_W'($urandom_range(0, 255)), rand_arg());
            else if (r < 92)
                put_conv(BYTE_W'($urandom_range(0, 255)), rand_arg());
            else if (r < 96)
                put_item(CH_NUL, rand_arg());
            else
                put_conv(CH_NUL, rand_arg());
            round++;
        end

        // Let everything drain, then a little slack
        drain();
        repeat (80) @(posedge clk);

        $display("Sent %0d format items, %0d of them in '%%' sequences.",
                 items_sent, 2 * pct_pairs);
        $display("Checked %0d output bytes against the predicted text.", bytes_checked);
        if (fail_count == 0 && pending_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Give up if the run hangs
    initial
    begin
        #40_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/pfe_pkg.sv
rtl/pfe_bin2bcd.sv
rtl/printf_format_engine_unit.sv
tb/pfe_stream_check.sv
tb/testbench.sv
